### design/sds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoke detector supervisor package
// Shared types, register indexes and reset values for the supervisor block.
// ----------------------------------------------------------------------------
package sds_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_ENABLE        = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ALARM_CONFIRM = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FAULT_CONFIRM = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_STANDBY_TMO   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ERROR_WINDOW  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_ERROR_REPEAT  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_RESEND_HOLD   = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [3:0]  ALARM_CONFIRM_RST = 4'd10;
  localparam logic [3:0]  FAULT_CONFIRM_RST = 4'd10;
  localparam logic [11:0] STANDBY_TMO_RST   = 12'd4000;
  localparam logic [8:0]  ERROR_WINDOW_RST  = 9'd300;
  localparam logic [2:0]  ERROR_REPEAT_RST  = 3'd5;
  localparam logic [7:0]  RESEND_HOLD_RST   = 8'd1;

  // Error pulse patterns that classify a window.
  localparam logic [7:0] PATTERN_BATTERY = 8'd1;
  localparam logic [7:0] PATTERN_EOL     = 8'd3;

  typedef struct packed {
    logic        enable;
    logic [3:0]  alarm_confirm_ticks;
    logic [3:0]  fault_confirm_ticks;
    logic [11:0] standby_timeout;
    logic [8:0]  error_window;
    logic [2:0]  error_repeat;
    logic [7:0]  resend_hold;
  } cfg_t;

  typedef struct packed {
    logic alarm_line;
    logic fault_pin;
    logic alarm_arm;
    logic standby_pulse;
    logic error_pulse;
    logic day_rollover;
  } item_t;

  typedef struct packed {
    logic smoke_alarm_event;
    logic tamper_open_event;
    logic tamper_close_event;
    logic low_battery_event;
    logic end_of_life_event;
    logic response_request;
  } result_t;

endpackage

### design/sds_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Supervisor configuration registers
// Write-only register file; each register takes the low bits of the data.
// ----------------------------------------------------------------------------
module sds_cfg_regs import sds_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ENABLE:        cfg_d.enable              = cfg_data_i[0];
        CFG_ALARM_CONFIRM: cfg_d.alarm_confirm_ticks = cfg_data_i[3:0];
        CFG_FAULT_CONFIRM: cfg_d.fault_confirm_ticks = cfg_data_i[3:0];
        CFG_STANDBY_TMO:   cfg_d.standby_timeout     = cfg_data_i[11:0];
        CFG_ERROR_WINDOW:  cfg_d.error_window        = cfg_data_i[8:0];
        CFG_ERROR_REPEAT:  cfg_d.error_repeat        = cfg_data_i[2:0];
        CFG_RESEND_HOLD:   cfg_d.resend_hold         = cfg_data_i[7:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable              <= 1'b0;
      cfg_q.alarm_confirm_ticks <= ALARM_CONFIRM_RST;
      cfg_q.fault_confirm_ticks <= FAULT_CONFIRM_RST;
      cfg_q.standby_timeout     <= STANDBY_TMO_RST;
      cfg_q.error_window        <= ERROR_WINDOW_RST;
      cfg_q.error_repeat        <= ERROR_REPEAT_RST;
      cfg_q.resend_hold         <= RESEND_HOLD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/sds_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Supervisor tick engine
// Holds the supervisor counters and advances them by one tick per step.
// ----------------------------------------------------------------------------
module sds_core import sds_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  output result_t result_o
);

  logic [3:0]  alarm_ticks_q, alarm_ticks_d;
  logic [3:0]  fault_ticks_q, fault_ticks_d;
  logic [11:0] standby_ticks_q, standby_ticks_d;
  logic [7:0]  pulse_count_q, pulse_count_d;
  logic [8:0]  quiet_ticks_q, quiet_ticks_d;
  logic [2:0]  pattern_repeats_q, pattern_repeats_d;
  logic [7:0]  battery_hold_q, battery_hold_d;
  logic [7:0]  eol_hold_q, eol_hold_d;

  logic [3:0]  ac, fc, alarm_start;
  logic [4:0]  alarm_sum, fault_sum;
  logic [12:0] standby_sum;
  logic [9:0]  quiet_sum;
  logic [2:0]  repeats_inc;
  logic [7:0]  bh_dec, eh_dec;
  logic        classified;
  result_t     res;

  always_comb begin
    alarm_ticks_d     = alarm_ticks_q;
    fault_ticks_d     = fault_ticks_q;
    standby_ticks_d   = standby_ticks_q;
    pulse_count_d     = pulse_count_q;
    quiet_ticks_d     = quiet_ticks_q;
    pattern_repeats_d = pattern_repeats_q;
    res               = '0;

    // Hold counters are counted down before anything else looks at them.
    bh_dec = (item_i.day_rollover && battery_hold_q != 8'd0) ?
             battery_hold_q - 8'd1 : battery_hold_q;
    eh_dec = (item_i.day_rollover && eol_hold_q != 8'd0) ?
             eol_hold_q - 8'd1 : eol_hold_q;
    battery_hold_d = bh_dec;
    eol_hold_d     = eh_dec;

    ac = (cfg_i.alarm_confirm_ticks == 4'd0) ? 4'd1 : cfg_i.alarm_confirm_ticks;
    fc = (cfg_i.fault_confirm_ticks == 4'd0) ? 4'd1 : cfg_i.fault_confirm_ticks;

    // Alarm confirmation.
    alarm_start = (item_i.alarm_arm && alarm_ticks_q == 4'd0) ? 4'd1 : alarm_ticks_q;
    alarm_sum   = {1'b0, alarm_start} + 5'd1;
    if (alarm_start != 4'd0) begin
      if (item_i.alarm_line) begin
        if (alarm_sum >= {1'b0, ac}) begin
          res.smoke_alarm_event = 1'b1;
          alarm_ticks_d         = 4'd0;
        end else begin
          alarm_ticks_d = alarm_sum[3:0];
        end
      end else begin
        alarm_ticks_d = 4'd0;
      end
    end else begin
      alarm_ticks_d = 4'd0;
    end

    // Fault pin debounce.
    fault_sum = {1'b0, fault_ticks_q} + 5'd1;
    if (item_i.fault_pin) begin
      if (fault_sum >= {1'b0, fc}) begin
        res.tamper_open_event = (fault_sum == {1'b0, fc});
        fault_ticks_d         = fc;
      end else begin
        fault_ticks_d = fault_sum[3:0];
      end
    end else begin
      res.tamper_close_event = (fault_ticks_q >= fc);
      fault_ticks_d          = 4'd0;
    end

    // Standby watchdog.
    standby_sum = {1'b0, standby_ticks_q} + 13'd1;
    if (item_i.standby_pulse) begin
      standby_ticks_d = 12'd0;
    end else if (standby_sum >= {1'b0, cfg_i.standby_timeout}) begin
      standby_ticks_d      = 12'd0;
      res.response_request = 1'b1;
    end else begin
      standby_ticks_d = standby_sum[11:0];
    end

    // Error pulse windows.
    quiet_sum   = {1'b0, quiet_ticks_q} + 10'd1;
    repeats_inc = (pattern_repeats_q != 3'd7) ? pattern_repeats_q + 3'd1
                                              : pattern_repeats_q;
    classified  = (pulse_count_q == PATTERN_BATTERY) || (pulse_count_q == PATTERN_EOL);
    if (item_i.error_pulse) begin
      if (pulse_count_q != 8'd255) begin
        pulse_count_d = pulse_count_q + 8'd1;
      end
      quiet_ticks_d = 9'd0;
    end else if (quiet_sum < {1'b0, cfg_i.error_window}) begin
      quiet_ticks_d = quiet_sum[8:0];
    end else if (pulse_count_q == 8'd0) begin
      quiet_ticks_d     = 9'd0;
      pattern_repeats_d = 3'd0;
    end else begin
      // The window closes on pulses.
      pulse_count_d = 8'd0;
      quiet_ticks_d = 9'd0;
      if (!classified) begin
        pattern_repeats_d = 3'd0;
      end else begin
        pattern_repeats_d = repeats_inc;
        if (repeats_inc >= cfg_i.error_repeat) begin
          if (pulse_count_q == PATTERN_BATTERY) begin
            if (bh_dec == 8'd0) begin
              res.low_battery_event = 1'b1;
              pattern_repeats_d     = 3'd0;
              battery_hold_d        = cfg_i.resend_hold;
            end
          end else if (eh_dec == 8'd0) begin
            res.end_of_life_event = 1'b1;
            pattern_repeats_d     = 3'd0;
            eol_hold_d            = cfg_i.resend_hold;
          end
        end
      end
    end

    // A disabled supervisor leaves every counter alone and reports nothing.
    if (!cfg_i.enable) begin
      alarm_ticks_d     = alarm_ticks_q;
      fault_ticks_d     = fault_ticks_q;
      standby_ticks_d   = standby_ticks_q;
      pulse_count_d     = pulse_count_q;
      quiet_ticks_d     = quiet_ticks_q;
      pattern_repeats_d = pattern_repeats_q;
      battery_hold_d    = battery_hold_q;
      eol_hold_d        = eol_hold_q;
      res               = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_ticks_q     <= '0;
      fault_ticks_q     <= '0;
      standby_ticks_q   <= '0;
      pulse_count_q     <= '0;
      quiet_ticks_q     <= '0;
      pattern_repeats_q <= '0;
      battery_hold_q    <= '0;
      eol_hold_q        <= '0;
    end else if (step_i) begin
      alarm_ticks_q     <= alarm_ticks_d;
      fault_ticks_q     <= fault_ticks_d;
      standby_ticks_q   <= standby_ticks_d;
      pulse_count_q     <= pulse_count_d;
      quiet_ticks_q     <= quiet_ticks_d;
      pattern_repeats_q <= pattern_repeats_d;
      battery_hold_q    <= battery_hold_d;
      eol_hold_q        <= eol_hold_d;
    end
  end

  assign result_o = res;

endmodule

### design/smoke_detector_supervisor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoke detector supervisor
// Per-tick supervision of a smoke detector's alarm, fault, standby and error
// lines, producing one set of one-tick event flags for every tick.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is one 100 ms tick, and for every tick
// exactly one transfer of event flags leaves on the output channel, in order.
// The block takes one tick per clock cycle when the output side does not
// stall. Each tick passes through the input register, where the counter
// update runs, and then through the result register. The sustained rate is
// set by the update of the supervisor counters, which carries each tick's
// state into the next. Configuration is written through a plain write port
// and should only be changed while no tick is in flight; with enable low,
// ticks still produce a result but every flag is zero and no counter moves.
// ----------------------------------------------------------------------------
module smoke_detector_supervisor import sds_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Tick input channel.
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                alarm_line_i,
  input  logic                fault_pin_i,
  input  logic                alarm_arm_i,
  input  logic                standby_pulse_i,
  input  logic                error_pulse_i,
  input  logic                day_rollover_i,
  // Event output channel.
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                smoke_alarm_event_o,
  output logic                tamper_open_event_o,
  output logic                tamper_close_event_o,
  output logic                low_battery_event_o,
  output logic                end_of_life_event_o,
  output logic                response_request_o
);

  cfg_t    cfg;
  item_t   item_q;
  logic    item_valid_q;
  result_t result_d, result_q;
  logic    result_valid_q;
  logic    result_free;
  logic    step;
  logic    in_take;

  // The result register is free when empty or when its flags leave this cycle.
  assign result_free = !result_valid_q || !out_stall_i;
  // The held tick moves into the result register, updating the counters.
  assign step        = item_valid_q && result_free;
  // The input register takes a tick whenever it is empty or being emptied.
  assign in_stall_o  = item_valid_q && !result_free;
  assign in_take     = in_valid_i && !in_stall_o;

  sds_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sds_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .cfg_i    (cfg),
    .item_i   (item_q),
    .result_o (result_d)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_take) begin
      item_valid_q <= 1'b1;
    end else if (step) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.alarm_line    <= alarm_line_i;
      item_q.fault_pin     <= fault_pin_i;
      item_q.alarm_arm     <= alarm_arm_i;
      item_q.standby_pulse <= standby_pulse_i;
      item_q.error_pulse   <= error_pulse_i;
      item_q.day_rollover  <= day_rollover_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else if (result_free) begin
      result_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o          = result_valid_q;
  assign smoke_alarm_event_o  = result_q.smoke_alarm_event;
  assign tamper_open_event_o  = result_q.tamper_open_event;
  assign tamper_close_event_o = result_q.tamper_close_event;
  assign low_battery_event_o  = result_q.low_battery_event;
  assign end_of_life_event_o  = result_q.end_of_life_event;
  assign response_request_o   = result_q.response_request;

endmodule

### tb/sv/smoke_detector_supervisor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoke detector supervisor testbench
// Drives ticks through the supervisor with random idling on both channels,
// predicts event flags from a behavioural copy of the block or takes typed
// ones from the directed table, and compares each field of every flag transfer.
// ----------------------------------------------------------------------------
module smoke_detector_supervisor_tb import sds_pkg::*; ();

  // Cycles with no transfer on either channel before the run is abandoned.
  localparam int unsigned WatchdogLimit = 1000;
  // Cycles waited after the last answered tick so that the block falls idle.
  localparam int unsigned DrainCycles   = 4;

  // A directed step either writes a register or offers one tick. Tick
  // columns read alarm_line, fault_pin, alarm_arm, standby_pulse, error_pulse,
  // day_rollover from left to right. Flag columns read smoke alarm, tamper
  // open, tamper close, low battery, end of life, response request.
  typedef enum logic {
    STEP_TICK,
    STEP_WRITE
  } step_kind_e;

  typedef struct packed {
    step_kind_e          kind;
    item_t               tick;
    logic                typed;
    result_t             want;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] reg_val;
  } directed_step_t;

  localparam int unsigned DirectedLen = 35;

  localparam directed_step_t DirectedSteps [DirectedLen] = '{
    // Out of reset the block is disabled, so every field must stay low,
    // even with all inputs high and a day rollover.
    '{STEP_TICK,  6'b111111, 1'b1, 6'b000000, CFG_ENABLE,        12'd0},
    '{STEP_TICK,  6'b000000, 1'b1, 6'b000000, CFG_ENABLE,        12'd0},
    // Enable alone, leaving every other register at its reset value.
    '{STEP_WRITE, 6'b000000, 1'b0, 6'b000000, CFG_ENABLE,        12'd1},
    '{STEP_TICK,  6'b101000, 1'b0, 6'b000000, CFG_ENABLE,        12'd0},
    '{STEP_TICK,  6'b010101, 1'b0, 6'b000000, CFG_ENABLE,        12'd0},
    '{STEP_TICK,  6'b000100, 1'b0, 6'b000000, CFG_ENABLE,        12'd0},
    // Every threshold at zero: confirm counts act as one, the watchdog
    // fires on each tick without a pulse, every quiet tick closes a window
    // and one classified window is enough, with nothing held back.
    '{STEP_WRITE, 6'b000000, 1'b0, 6'b000000, CFG_ALARM_CONFIRM, 12'd0},
    '{STEP_WRITE, 6'b000000, 1'b0, 6'b000000, CFG_FAULT_CONFIRM, 12'd0},
    '{STEP_WRITE, 6'b000000, 1'b0, 6'b000000, CFG_STANDBY_TMO,   12'd0},
    '{STEP_WRITE, 6'b000000, 1'b0, 6'b000000, CFG_ERROR_WINDOW,  12'd0},
    '{STEP_WRITE, 6'b000000, 1'b0, 6'b000000, CFG_ERROR_REPEAT,  12'd0},
    '{STEP_WRITE, 6'b000000, 1'b0, 6'b000000, CFG_RESEND_HOLD,   12'd0},
    '{STEP_TICK,  6'b101000, 1'b1, 6'b100001, CFG_ENABLE,        12'd0},
    '{STEP_TICK,  6'b010100, 1'b1, 6'b010000, CFG_ENABLE,        12'd0},
    '{STEP_TICK,  6'b010100, 1'b1, 6'b000000, CFG_ENABLE,        12'd0},
    '{STEP_TICK,  6'b000100, 1'b1, 6'b001000, CFG_ENABLE,        12'd0},
    // A single pulse then a quiet tick reports low battery.
    '{STEP_TICK,  6'b000110, 1'b1, 6'b000000, CFG_ENABLE,        12'd0},
    '{STEP_TICK,  6'b000100, 1'b1, 6'b000100, CFG_ENABLE,        12'd0},
    // Three pulses then a quiet tick report end of life.
    '{STEP_TICK,  6'b000110, 1'b1, 6'b000000, CFG_ENABLE,        12'd0},
    '{STEP_TICK,  6'b000110, 1'b1, 6'b000000, CFG_ENABLE,        12'd0},
    '{STEP_TICK,  6'b000110, 1'b1, 6'b000000, CFG_ENABLE,        12'd0},
    '{STEP_TICK,  6'b000100, 1'b1, 6'b000010, CFG_ENABLE,        12'd0},
    // Two pulses form no pattern and report nothing.
    '{STEP_TICK,  6'b000110, 1'b1, 6'b000000, CFG_ENABLE,        12'd0},
    '{STEP_TICK,  6'b000110, 1'b1, 6'b000000, CFG_ENABLE,        12'd0},
    '{STEP_TICK,  6'b000100, 1'b1, 6'b000000, CFG_ENABLE,        12'd0},
    // Every threshold at its largest value.
    '{STEP_WRITE, 6'b000000, 1'b0, 6'b000000, CFG_ALARM_CONFIRM, 12'd15},
    '{STEP_WRITE, 6'b000000, 1'b0, 6'b000000, CFG_FAULT_CONFIRM, 12'd15},
    '{STEP_WRITE, 6'b000000, 1'b0, 6'b000000, CFG_STANDBY_TMO,   12'd4095},
    '{STEP_WRITE, 6'b000000, 1'b0, 6'b000000, CFG_ERROR_WINDOW,  12'd511},
    '{STEP_WRITE, 6'b000000, 1'b0, 6'b000000, CFG_ERROR_REPEAT,  12'd7},
    '{STEP_WRITE, 6'b000000, 1'b0, 6'b000000, CFG_RESEND_HOLD,   12'd255},
    '{STEP_TICK,  6'b111111, 1'b0, 6'b000000, CFG_ENABLE,        12'd0},
    '{STEP_TICK,  6'b101010, 1'b0, 6'b000000, CFG_ENABLE,        12'd0},
    '{STEP_TICK,  6'b011001, 1'b0, 6'b000000, CFG_ENABLE,        12'd0},
    '{STEP_TICK,  6'b000000, 1'b0, 6'b000000, CFG_ENABLE,        12'd0}
  };

  // Every input of the block holds a known value from time zero.
  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i     = CFG_ENABLE;
  logic [CfgDataW-1:0] cfg_data_i      = '0;
  logic                in_valid_i      = 1'b0;
  logic                in_stall_o;
  logic                alarm_line_i    = 1'b0;
  logic                fault_pin_i     = 1'b0;
  logic                alarm_arm_i     = 1'b0;
  logic                standby_pulse_i = 1'b0;
  logic                error_pulse_i   = 1'b0;
  logic                day_rollover_i  = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i     = 1'b0;
  logic                smoke_alarm_event_o;
  logic                tamper_open_event_o;
  logic                tamper_close_event_o;
  logic                low_battery_event_o;
  logic                end_of_life_event_o;
  logic                response_request_o;

  smoke_detector_supervisor DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .alarm_line_i         (alarm_line_i),
    .fault_pin_i          (fault_pin_i),
    .alarm_arm_i          (alarm_arm_i),
    .standby_pulse_i      (standby_pulse_i),
    .error_pulse_i        (error_pulse_i),
    .day_rollover_i       (day_rollover_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .smoke_alarm_event_o  (smoke_alarm_event_o),
    .tamper_open_event_o  (tamper_open_event_o),
    .tamper_close_event_o (tamper_close_event_o),
    .low_battery_event_o  (low_battery_event_o),
    .end_of_life_event_o  (end_of_life_event_o),
    .response_request_o   (response_request_o)
  );

  // Shadow of the register file, kept in step with every write.
  cfg_t shadow_cfg = '{
    enable:              1'b0,
    alarm_confirm_ticks: ALARM_CONFIRM_RST,
    fault_confirm_ticks: FAULT_CONFIRM_RST,
    standby_timeout:     STANDBY_TMO_RST,
    error_window:        ERROR_WINDOW_RST,
    error_repeat:        ERROR_REPEAT_RST,
    resend_hold:         RESEND_HOLD_RST
  };

  // Shadow of the supervisor counters, all clear after reset.
  logic [3:0]  alarm_run     = '0;
  logic [3:0]  fault_run     = '0;
  logic [11:0] standby_age   = '0;
  logic [7:0]  pulse_tally   = '0;
  logic [8:0]  quiet_run     = '0;
  logic [2:0]  pattern_seen  = '0;
  logic [7:0]  battery_block = '0;
  logic [7:0]  eol_block     = '0;

  // Flags predicted for ticks already transferred, oldest first.
  result_t expected_flags [$];

  int mismatches = 0;
  int gap_pct    = 0;
  int stall_left = 0;
  int idle_edges = 0;

  // State of the random tick shaping: runs of pin levels and error pulse
  // bursts followed by quiet stretches around the window length.
  logic alarm_level     = 1'b0;
  logic fault_level     = 1'b0;
  int   alarm_len_left  = 0;
  int   fault_len_left  = 0;
  int   burst_left      = 0;
  int   hush_left       = 0;
  int   standby_pct     = 10;
  bit   flood_due       = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Advances the shadow counters by one tick and returns the flags that the
  // tick must raise.
  function automatic result_t supervise_tick(input item_t t);
    result_t     r;
    logic [4:0]  alarm_need;
    logic [4:0]  fault_need;
    logic [4:0]  alarm_next;
    logic [4:0]  fault_next;
    logic [12:0] standby_next;
    logic [9:0]  quiet_next;
    r = '0;
    if (!shadow_cfg.enable) begin
      return r;
    end

    // A day rollover counts the hold counters down before anything else.
    if (t.day_rollover) begin
      if (battery_block != 8'd0) battery_block = battery_block - 8'd1;
      if (eol_block != 8'd0) eol_block = eol_block - 8'd1;
    end

    alarm_need = (shadow_cfg.alarm_confirm_ticks == 4'd0) ? 5'd1 :
                 {1'b0, shadow_cfg.alarm_confirm_ticks};
    fault_need = (shadow_cfg.fault_confirm_ticks == 4'd0) ? 5'd1 :
                 {1'b0, shadow_cfg.fault_confirm_ticks};

    if (t.alarm_arm && alarm_run == 4'd0) alarm_run = 4'd1;
    if (alarm_run != 4'd0) begin
      if (t.alarm_line) begin
        alarm_next = {1'b0, alarm_run} + 5'd1;
        if (alarm_next >= alarm_need) begin
          r.smoke_alarm_event = 1'b1;
          alarm_next = '0;
        end
        alarm_run = alarm_next[3:0];
      end else begin
        alarm_run = '0;
      end
    end

    // The fault count sticks at the threshold while the pin stays high.
    if (t.fault_pin) begin
      fault_next = {1'b0, fault_run} + 5'd1;
      if (fault_next >= fault_need) begin
        if (fault_next == fault_need) r.tamper_open_event = 1'b1;
        fault_next = fault_need;
      end
      fault_run = fault_next[3:0];
    end else begin
      if ({1'b0, fault_run} >= fault_need) r.tamper_close_event = 1'b1;
      fault_run = '0;
    end

    if (t.standby_pulse) begin
      standby_age = '0;
    end else begin
      standby_next = {1'b0, standby_age} + 13'd1;
      if (standby_next >= {1'b0, shadow_cfg.standby_timeout}) begin
        standby_next = '0;
        r.response_request = 1'b1;
      end
      standby_age = standby_next[11:0];
    end

    if (t.error_pulse) begin
      if (pulse_tally != 8'hFF) pulse_tally = pulse_tally + 8'd1;
      quiet_run = '0;
    end else begin
      quiet_next = {1'b0, quiet_run} + 10'd1;
      quiet_run  = quiet_next[8:0];
      if (quiet_next >= {1'b0, shadow_cfg.error_window}) begin
        // The window closes; only one or three pulses classify it.
        if (pulse_tally == PATTERN_BATTERY || pulse_tally == PATTERN_EOL) begin
          if (pattern_seen != 3'd7) pattern_seen = pattern_seen + 3'd1;
          if (pattern_seen >= shadow_cfg.error_repeat) begin
            if (pulse_tally == PATTERN_BATTERY) begin
              if (battery_block == 8'd0) begin
                r.low_battery_event = 1'b1;
                pattern_seen  = '0;
                battery_block = shadow_cfg.resend_hold;
              end
            end else if (eol_block == 8'd0) begin
              r.end_of_life_event = 1'b1;
              pattern_seen = '0;
              eol_block    = shadow_cfg.resend_hold;
            end
          end
        end else begin
          pattern_seen = '0;
        end
        pulse_tally = '0;
        quiet_run   = '0;
      end
    end
    return r;
  endfunction

  // Builds the next random tick. Most ticks follow runs and bursts that
  // reach the confirm, debounce and pattern logic; the rest are noise.
  function automatic item_t next_random_tick();
    item_t t;
    t = '0;
    if (burst_left == 0 && $urandom_range(99) < 12) begin
      t = item_t'($urandom_range(63));
      return t;
    end

    if (alarm_len_left == 0) begin
      alarm_level    = 1'($urandom_range(1));
      alarm_len_left = $urandom_range(18, 1);
    end
    alarm_len_left--;
    if (fault_len_left == 0) begin
      fault_level    = 1'($urandom_range(1));
      fault_len_left = $urandom_range(20, 1);
    end
    fault_len_left--;

    if (burst_left == 0 && hush_left == 0) begin
      case ($urandom_range(9))
        0, 1, 2, 3: burst_left = 1;
        4, 5, 6, 7: burst_left = 3;
        8:          burst_left = 2;
        default:    burst_left = $urandom_range(6, 4);
      endcase
      // One long burst drives the pulse count into saturation.
      if (flood_due) begin
        burst_left = 260;
        flood_due  = 1'b0;
      end
      // Now and then the quiet stretch is cut short so windows merge.
      hush_left = ($urandom_range(4) == 0) ? $urandom_range(shadow_cfg.error_window) :
                  shadow_cfg.error_window + $urandom_range(3);
    end
    if (burst_left != 0) begin
      t.error_pulse = 1'b1;
      burst_left--;
    end else begin
      hush_left--;
    end

    t.alarm_line    = alarm_level;
    t.fault_pin     = fault_level;
    t.alarm_arm     = ($urandom_range(99) < 25);
    t.standby_pulse = ($urandom_range(99) < standby_pct);
    t.day_rollover  = ($urandom_range(99) < 6);
    return t;
  endfunction

  // Writes one register at the next rising edge and mirrors it. The write
  // enable is left high so that writes can follow back to back.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    case (idx)
      CFG_ENABLE:        shadow_cfg.enable              = value[0];
      CFG_ALARM_CONFIRM: shadow_cfg.alarm_confirm_ticks = value[3:0];
      CFG_FAULT_CONFIRM: shadow_cfg.fault_confirm_ticks = value[3:0];
      CFG_STANDBY_TMO:   shadow_cfg.standby_timeout     = value[11:0];
      CFG_ERROR_WINDOW:  shadow_cfg.error_window        = value[8:0];
      CFG_ERROR_REPEAT:  shadow_cfg.error_repeat        = value[2:0];
      CFG_RESEND_HOLD:   shadow_cfg.resend_hold         = value[7:0];
      default: ;
    endcase
  endtask

  // Presents one tick and holds it until the transfer, then records the
  // flags it must produce. A typed expectation replaces the prediction,
  // though the shadow counters still move.
  task automatic offer_tick(input item_t t, input logic typed, input result_t want);
    result_t predicted;
    in_valid_i      <= 1'b1;
    alarm_line_i    <= t.alarm_line;
    fault_pin_i     <= t.fault_pin;
    alarm_arm_i     <= t.alarm_arm;
    standby_pulse_i <= t.standby_pulse;
    error_pulse_i   <= t.error_pulse;
    day_rollover_i  <= t.day_rollover;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = supervise_tick(t);
    expected_flags.push_back(typed ? want : predicted);
  endtask

  // Sometimes holds the sender back for a burst of idle cycles.
  task automatic maybe_pause();
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(11, 1)) @(posedge clk_i);
    end
  endtask

  // Stops sending and waits until every outstanding tick has been answered
  // and the pipeline has had time to fall idle.
  task automatic drain_ticks();
    in_valid_i <= 1'b0;
    while (expected_flags.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic check_flag(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      mismatches++;
    end
  endtask

  // Receiving side: compares every flag transfer with the oldest prediction
  // and stalls the block in random bursts.
  always @(posedge clk_i) begin : collect_flags
    result_t seen;
    result_t due;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      seen = {smoke_alarm_event_o, tamper_open_event_o, tamper_close_event_o,
              low_battery_event_o, end_of_life_event_o, response_request_o};
      if (expected_flags.size() == 0) begin
        $error("flag transfer %b with no tick outstanding", seen);
        mismatches++;
      end else begin
        due = expected_flags.pop_front();
        check_flag("smoke_alarm_event", due.smoke_alarm_event, seen.smoke_alarm_event);
        check_flag("tamper_open_event", due.tamper_open_event, seen.tamper_open_event);
        check_flag("tamper_close_event", due.tamper_close_event, seen.tamper_close_event);
        check_flag("low_battery_event", due.low_battery_event, seen.low_battery_event);
        check_flag("end_of_life_event", due.end_of_life_event, seen.end_of_life_event);
        check_flag("response_request", due.response_request, seen.response_request);
      end
    end

    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      stall_left = $urandom_range(10);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o === 1'b1 && !out_stall_i)) begin
      idle_edges <= 0;
    end else if (idle_edges >= WatchdogLimit) begin
      $display("smoke_detector_supervisor_tb: done, errors");
      $finish;
    end else begin
      idle_edges <= idle_edges + 1;
    end
  end

  initial begin : stimulus
    cfg_t settings;
    bit   writing;
    int   phase;
    int   ticks;

    writing = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A register write only happens once every earlier
    // tick has been answered, so the block is idle when it lands.
    gap_pct = 25;
    for (int i = 0; i < DirectedLen; i++) begin
      if (DirectedSteps[i].kind == STEP_WRITE) begin
        if (!writing) drain_ticks();
        write_reg(DirectedSteps[i].reg_idx, DirectedSteps[i].reg_val);
        writing = 1'b1;
      end else begin
        if (writing) begin
          cfg_we_i <= 1'b0;
          writing = 1'b0;
        end
        maybe_pause();
        offer_tick(DirectedSteps[i].tick, DirectedSteps[i].typed, DirectedSteps[i].want);
      end
    end

    // Random part in phases, each under fresh settings. Counters carry over
    // from one phase to the next, so a lowered threshold can meet a count
    // that already exceeds it. Phase two holds the saturating burst, phase
    // five runs disabled, and the first and last phases run without idling.
    for (phase = 0; phase < 8; phase++) begin
      drain_ticks();
      settings.enable              = (phase != 5);
      settings.alarm_confirm_ticks = ($urandom_range(4) == 0) ? 4'd15 :
                                     4'($urandom_range(6, 1));
      settings.fault_confirm_ticks = ($urandom_range(4) == 0) ? 4'd15 :
                                     4'($urandom_range(6, 1));
      case ($urandom_range(9))
        0:       settings.standby_timeout = 12'd0;
        1:       settings.standby_timeout = 12'd4095;
        default: settings.standby_timeout = 12'($urandom_range(40, 1));
      endcase
      settings.error_window = ($urandom_range(9) == 0) ? 9'd0 : 9'($urandom_range(12, 1));
      settings.error_repeat = 3'($urandom_range(7));
      settings.resend_hold  = ($urandom_range(5) == 0) ? 8'd255 : 8'($urandom_range(3));

      write_reg(CFG_ENABLE,        CfgDataW'(settings.enable));
      write_reg(CFG_ALARM_CONFIRM, CfgDataW'(settings.alarm_confirm_ticks));
      write_reg(CFG_FAULT_CONFIRM, CfgDataW'(settings.fault_confirm_ticks));
      write_reg(CFG_STANDBY_TMO,   CfgDataW'(settings.standby_timeout));
      write_reg(CFG_ERROR_WINDOW,  CfgDataW'(settings.error_window));
      write_reg(CFG_ERROR_REPEAT,  CfgDataW'(settings.error_repeat));
      write_reg(CFG_RESEND_HOLD,   CfgDataW'(settings.resend_hold));
      cfg_we_i <= 1'b0;

      case ($urandom_range(2))
        0:       gap_pct = 8;
        1:       gap_pct = 15;
        default: gap_pct = 25;
      endcase
      if (phase == 0 || phase == 7) gap_pct = 0;
      standby_pct = $urandom_range(30, 2);
      flood_due   = (phase == 2);
      ticks       = (phase == 2) ? 420 : (phase == 5) ? 60 : 200;

      repeat (ticks) begin
        maybe_pause();
        offer_tick(next_random_tick(), 1'b0, '0);
      end
    end

    drain_ticks();
    if (mismatches == 0) begin
      $display("smoke_detector_supervisor_tb: done, clean");
    end else begin
      $display("smoke_detector_supervisor_tb: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
design/sds_pkg.sv
design/sds_cfg_regs.sv
design/sds_core.sv
design/smoke_detector_supervisor.sv
tb/sv/smoke_detector_supervisor_tb.sv
